// File: hdl/sqd_pkg.sv
package sqd_pkg;

    // Default sizing
    localparam int DEF_MAX_ENTRIES = 256;
    localparam int DEF_INDEX_BITS  = 16;

    // Field widths
    localparam int OP_BITS   = 2;
    localparam int IDX_BITS  = 16;
    localparam int VAL_BITS  = 16;
    localparam int SUM_BITS  = 48;
    localparam int SQ_BITS   = 2 * VAL_BITS;

    // Opcodes
    localparam logic [OP_BITS-1:0] OP_APPEND_A = 2'd0;
    localparam logic [OP_BITS-1:0] OP_STREAM_B = 2'd1;
    localparam logic [OP_BITS-1:0] OP_FINISH   = 2'd2;
    localparam logic [OP_BITS-1:0] OP_CLEAR    = 2'd3;

    typedef struct packed {
        logic [OP_BITS-1:0]         opcode;
        logic [IDX_BITS-1:0]        element_index;
        logic signed [VAL_BITS-1:0] element_value;
    } t_in;

    typedef struct packed {
        logic [SUM_BITS-1:0] squared_distance;
        logic                saturated;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_CMP,
        S_MUL,
        S_ACC,
        S_EMIT
    } t_state;

endpackage

// File: hdl/sparse_squared_distance.sv
// Sparse squared Euclidean distance. Vector A is loaded as (index, value) items with the
// append opcode into an internal store of MAX_ENTRIES entries; vector B is then streamed in
// ascending index order and merged against A, and the finish opcode adds the remaining A
// entries and delivers one result holding the unsigned integer (Q48.0) sum (saturated at
// 2^48-1) and a flag. Append and clear items are handled without leaving the idle state. A B
// item fetches, compares, squares and accumulates each stored entry with a smaller index,
// then squares its difference with a matching entry or its own value; a finish item does
// the same for every remaining entry and then waits until an earlier result has been read.
// The loop runs around the single read port of the store and the one shared 16x16 multiplier.
// The result sits in an output register, so new items are taken while it waits to be read.
module sparse_squared_distance #(
    parameter int MAX_ENTRIES = sqd_pkg::DEF_MAX_ENTRIES,
    parameter int INDEX_BITS  = sqd_pkg::DEF_INDEX_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sqd_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output sqd_pkg::t_out o_out
);
    import sqd_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = (INDEX_BITS < IDX_BITS) ? INDEX_BITS : IDX_BITS;
    localparam logic [CW-1:0]       MAX_COUNT = CW'(MAX_ENTRIES);
    localparam logic [SUM_BITS-1:0] SUM_MAX   = '1;

    // Store of vector A
    logic [IW-1:0]              r_mem_idx [MAX_ENTRIES];
    logic signed [VAL_BITS-1:0] r_mem_val [MAX_ENTRIES];
    logic [IW-1:0]              r_rd_idx;
    logic signed [VAL_BITS-1:0] r_rd_val;

    t_state r_state, n_state;
    logic [CW-1:0]              r_count, n_count;
    logic [CW-1:0]              r_wp, n_wp;
    logic [SUM_BITS-1:0]        r_sum, n_sum;
    logic                       r_ovf, n_ovf;
    logic [OP_BITS-1:0]         r_op, n_op;
    logic [IW-1:0]              r_idx, n_idx;
    logic signed [VAL_BITS-1:0] r_val, n_val;
    logic [VAL_BITS-1:0]        r_mag, n_mag;
    logic                       r_more, n_more;
    logic [SQ_BITS-1:0]         r_sq, n_sq;
    logic                       r_out_valid, n_out_valid;
    t_out                       r_out, n_out;

    logic                       w_accept;
    logic                       w_walk;
    logic                       w_append;
    logic [IW-1:0]              w_in_idx;
    logic signed [VAL_BITS:0]   w_diff;
    logic [SUM_BITS:0]          w_total;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_walk   = r_wp < r_count;
    assign w_append = w_accept && (i_in.opcode == OP_APPEND_A) && (r_count < MAX_COUNT);
    assign w_in_idx = i_in.element_index[IW-1:0];
    assign w_total  = {1'b0, r_sum} + {{(SUM_BITS + 1 - SQ_BITS){1'b0}}, r_sq};

    // Write on append, read at the walk pointer every cycle
    always_ff @(posedge i_clk) begin
        if (w_append) begin
            r_mem_idx[r_count[AW-1:0]] <= w_in_idx;
            r_mem_val[r_count[AW-1:0]] <= i_in.element_value;
        end
        r_rd_idx <= r_mem_idx[r_wp[AW-1:0]];
        r_rd_val <= r_mem_val[r_wp[AW-1:0]];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_in.opcode == OP_STREAM_B || i_in.opcode == OP_FINISH)) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                if (w_walk || r_op == OP_STREAM_B) begin
                    n_state = w_walk ? S_CMP : S_MUL;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_CMP: n_state = S_MUL;
            S_MUL: n_state = S_ACC;
            S_ACC: n_state = r_more ? S_FETCH : S_IDLE;
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_count     = r_count;
        n_wp        = r_wp;
        n_sum       = r_sum;
        n_ovf       = r_ovf;
        n_op        = r_op;
        n_idx       = r_idx;
        n_val       = r_val;
        n_mag       = r_mag;
        n_more      = r_more;
        n_sq        = r_mag * r_mag;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        w_diff      = {r_rd_val[VAL_BITS-1], r_rd_val} - {r_val[VAL_BITS-1], r_val};
        o_in_ready  = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op  = i_in.opcode;
                    n_idx = w_in_idx;
                    n_val = i_in.element_value;
                    if (w_append) begin
                        n_count = r_count + 1'b1;
                    end
                    if (i_in.opcode == OP_CLEAR) begin
                        n_count = '0;
                        n_wp    = '0;
                        n_sum   = '0;
                        n_ovf   = 1'b0;
                    end
                end
            end
            S_FETCH: begin
                // no partner left: square the B value itself
                n_mag  = r_val[VAL_BITS-1] ? VAL_BITS'(-r_val) : VAL_BITS'(r_val);
                n_more = 1'b0;
            end
            S_CMP: begin
                if (r_op == OP_FINISH || r_rd_idx < r_idx) begin
                    // unmatched A entry: square it and keep walking
                    n_mag  = r_rd_val[VAL_BITS-1] ? VAL_BITS'(-r_rd_val) : VAL_BITS'(r_rd_val);
                    n_more = 1'b1;
                    n_wp   = r_wp + 1'b1;
                end else if (r_rd_idx == r_idx) begin
                    n_mag  = w_diff[VAL_BITS] ? VAL_BITS'(-w_diff) : VAL_BITS'(w_diff);
                    n_more = 1'b0;
                    n_wp   = r_wp + 1'b1;
                end else begin
                    n_mag  = r_val[VAL_BITS-1] ? VAL_BITS'(-r_val) : VAL_BITS'(r_val);
                    n_more = 1'b0;
                end
            end
            S_ACC: begin
                // saturate once the sum reaches its maximum
                if (r_sum == SUM_MAX || w_total >= {1'b0, SUM_MAX}) begin
                    n_sum = SUM_MAX;
                    n_ovf = 1'b1;
                end else begin
                    n_sum = w_total[SUM_BITS-1:0];
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.squared_distance = r_sum;
                    n_out.saturated        = r_ovf;
                    n_out_valid            = 1'b1;
                    n_wp                   = '0;
                    n_sum                  = '0;
                    n_ovf                  = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_wp        <= '0;
            r_sum       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_wp        <= n_wp;
            r_sum       <= n_sum;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_idx  <= n_idx;
        r_val  <= n_val;
        r_mag  <= n_mag;
        r_more <= n_more;
        r_sq   <= n_sq;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: hdl/sqd_checker.sv
module sqd_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input sqd_pkg::t_in  i_in,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input sqd_pkg::t_out o_out
);
    import sqd_pkg::*;

    // Hold a waiting result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // Busy after a streamed B item
    a_b_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in.opcode == OP_STREAM_B |=> !o_in_ready)
        else $error("ready right after a B item");

    // Busy after a finish item
    a_fin_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in.opcode == OP_FINISH |=> !o_in_ready)
        else $error("ready right after a finish item");

    // Flag only with a full-scale sum
    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.saturated |-> o_out.squared_distance == '1)
        else $error("saturated flag without maximum sum");

    // Drop result after reset
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind sparse_squared_distance sqd_checker u_sqd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
